// File: sv/assert_macros.svh
// Assertion macros used by the top RTL file of the cursor tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of clk_i, disabled while in reset.
`define PS2MCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when ante holds, cons holds at the next edge.
`define PS2MCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `PS2MCT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: sv/ps2mct_pkg.sv
// Types and constants of the PS/2 mouse packet cursor tracker.
`default_nettype none

package ps2mct_pkg;

  // header byte bit positions
  localparam int unsigned BitLeft   = 0;
  localparam int unsigned BitRight  = 1;
  localparam int unsigned BitMiddle = 2;
  localparam int unsigned BitSync   = 3;
  localparam int unsigned BitXSign  = 4;
  localparam int unsigned BitYSign  = 5;

  localparam logic [11:0] StartPos       = 12'd500;
  localparam logic [11:0] WidthReset     = 12'd1024;
  localparam logic [11:0] HeightReset    = 12'd768;
  localparam logic [4:0]  MarginX        = 5'd8;
  localparam logic [4:0]  MarginY        = 5'd16;

  // configuration register indexes
  localparam logic CfgScreenWidth  = 1'b0;
  localparam logic CfgScreenHeight = 1'b1;

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhDx     = 2'd1,
    PhDy     = 2'd2
  } phase_e;

  typedef struct packed {
    logic left;
    logic middle;
    logic right;
    logic changed;
  } btn_t;

endpackage

`default_nettype wire

// File: sv/ps2mct_clamp.sv
// Clamps a signed coordinate to 0 .. min(extent - margin, coordinate max).
`default_nettype none

module ps2mct_clamp #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic signed [COORD_BITS+1:0] value_i,
  input  logic        [11:0]           extent_i,
  input  logic        [4:0]            margin_i,
  output logic        [COORD_BITS-1:0] coord_o
);

  localparam int unsigned Vw = COORD_BITS + 2;
  localparam logic [Vw-1:0] CoordMax = {2'b00, {COORD_BITS{1'b1}}};

  logic [11:0]   hi;
  logic [Vw-1:0] hi_w;
  logic [Vw-1:0] res;

  always_comb begin
    if (extent_i >= {7'd0, margin_i}) begin
      hi = extent_i - {7'd0, margin_i};
    end else begin
      hi = 12'd0;
    end
    hi_w = Vw'(hi);
    if (hi_w > CoordMax) begin
      hi_w = CoordMax;
    end
    if (value_i < 0) begin
      res = '0;
    end else if ($unsigned(value_i) > hi_w) begin
      res = hi_w;
    end else begin
      res = $unsigned(value_i);
    end
  end

  assign coord_o = res[COORD_BITS-1:0];

endmodule

`default_nettype wire

// File: sv/ps2mct_core.sv
// Packet framing, cursor update and button tracking for one byte per step.
`default_nettype none

module ps2mct_core import ps2mct_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic [11:0]           width_i,
  input  logic [11:0]           height_i,
  output logic                  res_valid_o,
  output logic [COORD_BITS-1:0] res_x_o,
  output logic [COORD_BITS-1:0] res_y_o,
  output btn_t                  res_btn_o
);

  localparam int unsigned Vw = COORD_BITS + 2;

  phase_e                phase_q, phase_d;
  logic [7:0]            hdr_q;
  logic [7:0]            dx_q;
  logic [COORD_BITS-1:0] pos_x_q;
  logic [COORD_BITS-1:0] pos_y_q;
  logic [2:0]            held_q;

  logic                  hdr_we;
  logic                  dx_we;
  logic signed [Vw-1:0]  dx_w;
  logic signed [Vw-1:0]  dy_w;
  logic signed [Vw-1:0]  nx;
  logic signed [Vw-1:0]  ny;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [2:0]            newb;

  // next phase
  always_comb begin
    case (phase_q)
      PhDx:    phase_d = PhDy;
      PhDy:    phase_d = PhHeader;
      default: phase_d = byte_i[BitSync] ? PhDx : PhHeader;
    endcase
  end

  // per-phase outputs
  always_comb begin
    hdr_we      = 1'b0;
    dx_we       = 1'b0;
    res_valid_o = 1'b0;
    case (phase_q)
      PhDx:    dx_we = 1'b1;
      PhDy:    res_valid_o = 1'b1;
      default: hdr_we = byte_i[BitSync];
    endcase
  end

  // 9-bit movement with header sign, sign extended
  assign dx_w = Vw'($signed({hdr_q[BitXSign], dx_q}));
  assign dy_w = Vw'($signed({hdr_q[BitYSign], byte_i}));
  assign nx   = $signed({2'b00, pos_x_q}) + dx_w;
  assign ny   = $signed({2'b00, pos_y_q}) - dy_w;

  ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
    .value_i  (nx),
    .extent_i (width_i),
    .margin_i (MarginX),
    .coord_o  (cx)
  );

  ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
    .value_i  (ny),
    .extent_i (height_i),
    .margin_i (MarginY),
    .coord_o  (cy)
  );

  assign newb = hdr_q[2:0];

  assign res_x_o           = cx;
  assign res_y_o           = cy;
  assign res_btn_o.left    = hdr_q[BitLeft];
  assign res_btn_o.middle  = hdr_q[BitMiddle];
  assign res_btn_o.right   = hdr_q[BitRight];
  assign res_btn_o.changed = (newb != held_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_x_q <= COORD_BITS'(StartPos);
      pos_y_q <= COORD_BITS'(StartPos);
      held_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      if (res_valid_o) begin
        pos_x_q <= cx;
        pos_y_q <= cy;
        held_q  <= newb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && hdr_we) begin
      hdr_q <= byte_i;
    end
    if (step_i && dx_we) begin
      dx_q <= byte_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/ps2mct_unit.sv
// Output register stage holding one finished result.
`default_nettype none

module ps2mct_unit import ps2mct_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [COORD_BITS-1:0] x_i,
  input  logic [COORD_BITS-1:0] y_i,
  input  btn_t                  btn_i,
  input  logic                  ready_i,
  output logic                  valid_o,
  output logic                  free_o,
  output logic [COORD_BITS-1:0] x_o,
  output logic [COORD_BITS-1:0] y_o,
  output btn_t                  btn_o
);

  logic                  valid_q, valid_d;
  logic [COORD_BITS-1:0] x_q;
  logic [COORD_BITS-1:0] y_q;
  btn_t                  btn_q;

  // slot can take a new result when empty or being drained this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      btn_q <= btn_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign btn_o   = btn_q;

endmodule

`default_nettype wire

// File: sv/ps2_mouse_packet_cursor_tracker_unit.sv
// A byte accepted into the input stage register is processed by the core when
// that stage advances; a packet's third byte then loads the result register.
// Throughput: one byte per cycle, unless a third byte waits on a full result slot.
// The result register holds a packet while a new byte still enters.
// Reset: phase awaits a header, cursor at 500,500, buttons released,
// screen 1024 x 768; no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module ps2_mouse_packet_cursor_tracker_unit import ps2mct_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [11:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic                  left_down_o,
  output logic                  middle_down_o,
  output logic                  right_down_o,
  output logic                  buttons_changed_o
);

  logic [11:0]           width_q;
  logic [11:0]           height_q;
  logic                  s1_valid_q;
  logic [7:0]            s1_byte_q;
  logic                  s1_adv;
  logic                  res_valid;
  logic                  out_free;
  logic                  load;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  btn_t                  res_btn;
  btn_t                  out_btn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgScreenWidth:  width_q  <= cfg_data_i;
        CfgScreenHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage advances unless it holds a third byte and the result slot is full
  assign s1_adv     = s1_valid_q && (!res_valid || out_free);
  assign load       = s1_adv && res_valid;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  ps2mct_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .byte_i      (s1_byte_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .res_valid_o (res_valid),
    .res_x_o     (res_x),
    .res_y_o     (res_y),
    .res_btn_o   (res_btn)
  );

  ps2mct_unit #(.COORD_BITS(COORD_BITS)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .x_i     (res_x),
    .y_i     (res_y),
    .btn_i   (res_btn),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .free_o  (out_free),
    .x_o     (cursor_x_o),
    .y_o     (cursor_y_o),
    .btn_o   (out_btn)
  );

  assign left_down_o       = out_btn.left;
  assign middle_down_o     = out_btn.middle;
  assign right_down_o      = out_btn.right;
  assign buttons_changed_o = out_btn.changed;

  `PS2MCT_ASSERT_NEXT(a_load_shows, load, out_valid_o, "loaded result not presented")
  `PS2MCT_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_adv,
                      s1_valid_q && $stable(s1_byte_q), "stalled input stage changed")
  `PS2MCT_ASSERT(a_stall_cause, !in_ready_o |-> (s1_valid_q && res_valid && out_valid_o),
                 "input stalled without a full result slot")

endmodule

`default_nettype wire
